// ===== hdl/wpdd_pkg.sv =====
// wpdd_pkg: constants, register map and helper functions for the windowed pid
// differential-drive block. No dependencies; used by the top level and the testbench.

package wpdd_pkg;

  // error window depth (range 2..64)
  localparam int WINDOW_DEPTH = 11;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int ERR_W        = 16;
  localparam int SUM_W        = $clog2(WINDOW_DEPTH) + ERR_W;

  // shared multiplier: 17-bit gain/track operand times 33-bit data operand
  localparam int MA_W   = 17;
  localparam int MB_W   = 33;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = ERR_W + SUM_W + 2;

  // turn rate scaling: w = round(acc * 256 / 100)
  localparam int DIV_CONST  = 100;
  localparam int ROUND_HALF = DIV_CONST / 2;
  localparam int W_SHIFT    = 8;
  localparam int NUM_W      = ((ACC_W + W_SHIFT + 1 + 3) / 4) * 4;
  localparam int DIV_STEPS  = NUM_W / 4;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int REM_W      = 7;
  localparam int DIGIT_W    = REM_W + 4;

  // wheel offset: delta = round(w * track / 2^17)
  localparam int DELTA_SHIFT = 17;

  // configuration port
  localparam int NUM_REGS  = 5;
  localparam int APB_AW    = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W = APB_AW - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BASE_SPEED  = 3'd0,
    REG_TRACK_WIDTH = 3'd1,
    REG_GAIN_P      = 3'd2,
    REG_GAIN_I      = 3'd3,
    REG_GAIN_D      = 3'd4
  } reg_idx_t;

  localparam logic signed [31:0] BASE_SPEED_RST  = 32'sd19661;
  localparam logic [15:0]        TRACK_WIDTH_RST = 16'd25139;
  localparam logic signed [15:0] GAIN_P_RST      = 16'sd256;
  localparam logic signed [15:0] GAIN_I_RST      = 16'sd26;
  localparam logic signed [15:0] GAIN_D_RST      = 16'sd0;

  // one radix-16 quotient digit of a division by DIV_CONST
  function automatic logic [3:0] div_digit(input logic [DIGIT_W-1:0] v);
    logic [3:0] d;
    d = '0;
    for (int k = 1; k < 16; k++) begin
      if (v >= DIGIT_W'(DIV_CONST * k)) d = 4'(k);
    end
    return d;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== hdl/wpdd_ram.sv =====
// wpdd_ram: generic single-write, single-read ram with registered read data.
// No package dependency.

module wpdd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/windowed_pid_differential_drive_top.sv =====
// windowed pid line follower with differential-drive wheel speeds.
// a request passes the window update, the three gain products, the radix-16 divide
// by 100, saturation, the track width product and the output state; a new request is
// taken only after that. The three gains and the track width share one multiplier.
// reset: synchronous, clears the window (fill count, pointer, sum, previous error)
// and loads the register defaults; the error ram itself is not cleared.

module windowed_pid_differential_drive_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [15:0]             line_error,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             left_speed,
  output logic signed [31:0]             right_speed,
  output logic signed [31:0]             turn_rate,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wpdd_pkg::APB_AW-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  import wpdd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RING, S_MUL_P, S_MUL_I, S_MUL_D, S_ACC, S_SCALE,
    S_DIV, S_SAT, S_TRACK, S_DELTA, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic signed [31:0] base_speed;
  logic [15:0]        track_width;
  logic signed [15:0] gain_p;
  logic signed [15:0] gain_i;
  logic signed [15:0] gain_d;

  // window state
  logic [PTR_W-1:0]        wp;
  logic [FILL_W-1:0]       fill;
  logic signed [SUM_W-1:0] window_sum;
  logic signed [ERR_W-1:0] previous_error;

  // datapath registers
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W:0]    diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     neg;
  logic [NUM_W-1:0]         num;
  logic [NUM_W-1:0]         quo;
  logic [REM_W-1:0]         rem;
  logic [STEP_W-1:0]        cnt;
  logic signed [31:0]       w;
  logic signed [31:0]       delta;

  logic [ERR_W-1:0] ram_rdata;
  logic             ram_we;

  logic                     ring_full;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [ACC_W-1:0]  acc_next;
  logic [ACC_W-1:0]         acc_mag;
  logic [DIGIT_W-1:0]       div_v;
  logic [3:0]               div_d;
  logic [PROD_W-1:0]        p_mag;
  logic [PROD_W-1:0]        p_q;
  logic signed [31:0]       w_next;
  logic signed [33:0]       left_full;
  logic signed [33:0]       right_full;
  logic                     in_take;
  logic                     cfg_wr;

  assign pready   = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign ram_we   = (state == S_RING);

  wpdd_ram #(
    .WIDTH (ERR_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (err),
    .raddr (wp),
    .rdata (ram_rdata)
  );

  always_comb begin
    ring_full = (fill == FILL_W'(WINDOW_DEPTH));
    sum_next  = window_sum + SUM_W'(err);
    if (ring_full) begin
      sum_next = sum_next - SUM_W'($signed(ram_rdata));
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_P: begin
        mul_a = MA_W'(gain_p);
        mul_b = MB_W'(err);
      end
      S_MUL_I: begin
        mul_a = MA_W'(gain_i);
        mul_b = MB_W'(window_sum);
      end
      S_MUL_D: begin
        mul_a = MA_W'(gain_d);
        mul_b = MB_W'(diff);
      end
      S_TRACK: begin
        mul_a = $signed({1'b0, track_width});
        mul_b = MB_W'(w);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;
  assign acc_next  = acc + ACC_W'(prod);
  assign acc_mag   = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

  assign div_v = {rem, num[NUM_W-1 -: 4]};
  assign div_d = div_digit(div_v);

  // saturate the magnitude quotient back to a signed turn rate
  always_comb begin
    if (!neg) begin
      w_next = (quo > NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
    end else begin
      w_next = (quo > NUM_W'(33'h0_8000_0000)) ? 32'sh8000_0000 : -$signed(quo[31:0]);
    end
  end

  // round half away from zero on the track product
  assign p_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign p_q   = (p_mag + PROD_W'(1 << (DELTA_SHIFT - 1))) >> DELTA_SHIFT;

  assign left_full  = 34'(base_speed) - 34'(delta);
  assign right_full = 34'(base_speed) + 34'(delta);

  always_comb begin
    prdata = '0;
    unique case (paddr[APB_AW-1:2])
      REG_BASE_SPEED:  prdata = base_speed;
      REG_TRACK_WIDTH: prdata = {16'd0, track_width};
      REG_GAIN_P:      prdata = 32'(gain_p);
      REG_GAIN_I:      prdata = 32'(gain_i);
      REG_GAIN_D:      prdata = 32'(gain_d);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      wp             <= '0;
      fill           <= '0;
      window_sum     <= '0;
      previous_error <= '0;
      base_speed     <= BASE_SPEED_RST;
      track_width    <= TRACK_WIDTH_RST;
      gain_p         <= GAIN_P_RST;
      gain_i         <= GAIN_I_RST;
      gain_d         <= GAIN_D_RST;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[APB_AW-1:2])
          REG_BASE_SPEED:  base_speed  <= pwdata;
          REG_TRACK_WIDTH: track_width <= pwdata[15:0];
          REG_GAIN_P:      gain_p      <= pwdata[15:0];
          REG_GAIN_I:      gain_i      <= pwdata[15:0];
          REG_GAIN_D:      gain_d      <= pwdata[15:0];
          default: ;
        endcase
      end

      // the output state reloads the result register itself
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      prod <= prod_next;

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            err   <= line_error;
            state <= S_RING;
          end
        end
        S_RING: begin
          // old entry at wp is on the ram output now; overwrite it
          window_sum     <= sum_next;
          diff           <= (ERR_W+1)'(err) - (ERR_W+1)'(previous_error);
          previous_error <= err;
          if (!ring_full) fill <= fill + 1'b1;
          wp    <= (wp == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp + 1'b1;
          state <= S_MUL_P;
        end
        S_MUL_P: state <= S_MUL_I;
        S_MUL_I: begin
          acc   <= ACC_W'(prod);
          state <= S_MUL_D;
        end
        S_MUL_D: begin
          acc   <= acc_next;
          state <= S_ACC;
        end
        S_ACC: begin
          acc   <= acc_next;
          state <= S_SCALE;
        end
        S_SCALE: begin
          neg   <= acc[ACC_W-1];
          num   <= (NUM_W'(acc_mag) << W_SHIFT) + NUM_W'(ROUND_HALF);
          quo   <= '0;
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= REM_W'(div_v - DIGIT_W'(div_d * DIV_CONST));
          quo <= {quo[NUM_W-5:0], div_d};
          num <= num << 4;
          cnt <= cnt + 1'b1;
          if (cnt == STEP_W'(DIV_STEPS - 1)) state <= S_SAT;
        end
        S_SAT: begin
          w     <= w_next;
          state <= S_TRACK;
        end
        S_TRACK: state <= S_DELTA;
        S_DELTA: begin
          delta <= prod[PROD_W-1] ? -$signed(p_q[31:0]) : $signed(p_q[31:0]);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            left_speed  <= sat32(left_full);
            right_speed <= sat32(right_full);
            turn_rate   <= w;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/wpdd_checker.sv =====
// wpdd_checker: port-level assertions for the windowed pid drive block,
// bound to windowed_pid_differential_drive_top. No package dependency.

module wpdd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] left_speed,
  input logic [31:0] right_speed,
  input logic [31:0] turn_rate
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(left_speed) &&
      $stable(right_speed) && $stable(turn_rate))
    else $error("stalled result changed");

  // one request at a time: busy right after taking a request
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous still in work");

  // a new result only appears at the end of a request's work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in work");

  // finishing a request always leaves a result behind
  a_done_gives_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(in_stall) |-> out_valid)
    else $error("request finished without a result");

endmodule

bind windowed_pid_differential_drive_top wpdd_checker u_wpdd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .left_speed  (left_speed),
  .right_speed (right_speed),
  .turn_rate   (turn_rate)
);

// ===== tb/sv/testbench.sv =====
// testbench for windowed_pid_differential_drive_top: sends line error samples and
// register writes, predicts each wheel command and compares it on the result channel.
// depends on wpdd_pkg and the top level only.

module testbench;
  import wpdd_pkg::*;

  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic signed [31:0] turn;
  } wheel_cmd_t;

  typedef enum {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [31:0] data;
    bit          typed;
    wheel_cmd_t  cmd;
  } stim_row_t;

  localparam longint SAT_MAX = 64'sh7FFF_FFFF;
  localparam longint SAT_MIN = -64'sh8000_0000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 180;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [15:0]   line_error = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [31:0]   left_speed, right_speed, turn_rate;
  logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  bit steady = 1'b0;
  int mismatch_count = 0, samples_sent = 0, reg_writes = 0, turn_clipped = 0;
  wheel_cmd_t wheel_cmd_q[$];

  // window and register shadow of the block
  logic signed [15:0] err_ring [WINDOW_DEPTH];
  int     ring_wp = 0, ring_fill = 0;
  longint ring_sum = 0, last_err = 0;
  longint base_q = BASE_SPEED_RST, track_q = TRACK_WIDTH_RST;
  longint kp = GAIN_P_RST, ki = GAIN_I_RST, kd = GAIN_D_RST;

  // requests in order; typed commands are the ones readable at a glance
  stim_row_t directed_rows [42] = '{
    '{ROW_SAMPLE, '0, 0, 1'b1, '{19661, 19661, 0}},
    '{ROW_SAMPLE, '0, 32767, 1'b0, '0},
    '{ROW_SAMPLE, '0, -32768, 1'b0, '0},
    '{ROW_SAMPLE, '0, 1, 1'b0, '0},
    '{ROW_SAMPLE, '0, -1, 1'b0, '0},
    '{ROW_WRITE, REG_GAIN_P, 0, 1'b0, '0},
    '{ROW_WRITE, REG_GAIN_I, 0, 1'b0, '0},
    '{ROW_WRITE, REG_GAIN_D, 0, 1'b0, '0},
    '{ROW_WRITE, REG_BASE_SPEED, 32'h8000_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 12345, 1'b1, '{32'sh8000_0000, 32'sh8000_0000, 0}},
    '{ROW_WRITE, REG_GAIN_P, 32'h7FFF, 1'b0, '0},
    '{ROW_WRITE, REG_TRACK_WIDTH, 0, 1'b0, '0},
    '{ROW_WRITE, REG_BASE_SPEED, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32767, 1'b1, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}},
    '{ROW_WRITE, REG_GAIN_P, 32'hFFFF_8000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32767, 1'b1, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000}},
    '{ROW_WRITE, REG_TRACK_WIDTH, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32767, 1'b0, '0},
    '{ROW_WRITE, REG_BASE_SPEED, 32'h8000_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, -32768, 1'b0, '0},
    '{ROW_WRITE, REG_GAIN_D, 32'h7FFF, 1'b0, '0},
    '{ROW_WRITE, REG_GAIN_P, 0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32767, 1'b0, '0},
    '{ROW_SAMPLE, '0, -32768, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32767, 1'b0, '0},
    '{ROW_WRITE, REG_GAIN_D, 0, 1'b0, '0},
    '{ROW_WRITE, REG_GAIN_I, 32'h7FFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32767, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32767, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32767, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32767, 1'b0, '0},
    '{ROW_SAMPLE, '0, -32768, 1'b0, '0},
    // writes past the last register must change nothing
    '{ROW_WRITE, 3'(NUM_REGS), 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_WRITE, 3'(NUM_REGS + 1), 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_WRITE, 3'(NUM_REGS + 2), 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 100, 1'b0, '0},
    '{ROW_WRITE, REG_GAIN_I, 0, 1'b0, '0},
    '{ROW_WRITE, REG_GAIN_P, 1, 1'b0, '0},
    '{ROW_WRITE, REG_BASE_SPEED, 0, 1'b0, '0},
    '{ROW_WRITE, REG_TRACK_WIDTH, 1, 1'b0, '0},
    // wheel offset of exactly one half rounds away from zero
    '{ROW_SAMPLE, '0, 25600, 1'b1, '{-1, 1, 65536}},
    '{ROW_SAMPLE, '0, -25600, 1'b1, '{1, -1, -65536}}
  };

  windowed_pid_differential_drive_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .line_error(line_error),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_speed(left_speed), .right_speed(right_speed), .turn_rate(turn_rate),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 800_000);
    $display("Verification failed");
    $finish;
  end

  function automatic longint div_nearest(input longint num, input longint den);
    longint q;
    q = (((num < 0) ? -num : num) + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clip32(input longint v);
    return (v > SAT_MAX) ? SAT_MAX : (v < SAT_MIN) ? SAT_MIN : v;
  endfunction

  function automatic wheel_cmd_t steer_predict(input logic signed [15:0] e);
    longint acc, w, delta;
    wheel_cmd_t c;
    // oldest sample leaves the sum only once the window is full
    if (ring_fill >= WINDOW_DEPTH) ring_sum -= err_ring[ring_wp];
    else ring_fill++;
    err_ring[ring_wp] = e;
    ring_sum += e;
    ring_wp = (ring_wp == WINDOW_DEPTH - 1) ? 0 : ring_wp + 1;
    acc = kp * e + ki * ring_sum + kd * (e - last_err);
    last_err = e;
    w = clip32(div_nearest(acc * (1 << W_SHIFT), DIV_CONST));
    delta = div_nearest(w * track_q, longint'(1) << DELTA_SHIFT);
    c.left = 32'(clip32(base_q - delta));
    c.right = 32'(clip32(base_q + delta));
    c.turn = 32'(w);
    return c;
  endfunction

  // psel stays high between back-to-back accesses; send_sample closes the bus
  task automatic apb_xfer(input bit wr, input logic [2:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] d);
    logic [31:0] rd, mask;
    apb_xfer(1'b1, idx, d, rd);
    reg_writes++;
    mask = (idx == REG_BASE_SPEED) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    case (idx)
      REG_BASE_SPEED:  base_q = longint'($signed(d));
      REG_TRACK_WIDTH: track_q = longint'(d[15:0]);
      REG_GAIN_P:      kp = longint'($signed(d[15:0]));
      REG_GAIN_I:      ki = longint'($signed(d[15:0]));
      REG_GAIN_D:      kd = longint'($signed(d[15:0]));
      default: ;
    endcase
    if (idx < NUM_REGS) begin
      apb_xfer(1'b0, idx, '0, rd);
      if ((rd & mask) !== (d & mask)) begin
        mismatch_count++;
        $display("%0t: register %0d read back expected %h got %h", $time, idx, d & mask,
                 rd & mask);
      end
    end
  endtask

  task automatic send_sample(input logic signed [15:0] e, input bit typed,
                             input wheel_cmd_t given);
    wheel_cmd_t c;
    psel <= 1'b0;
    penable <= 1'b0;
    if (!steady) begin
      while ($urandom_range(99) < 22) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    line_error <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    c = steer_predict(e);
    if (c.turn == 32'sh7FFF_FFFF || c.turn == 32'sh8000_0000) turn_clipped++;
    wheel_cmd_q.insert(wheel_cmd_q.size(), typed ? given : c);
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (wheel_cmd_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 22);
  end

  always @(posedge clk) begin
    wheel_cmd_t want;
    if (!rst && out_valid && !out_stall) begin
      if (wheel_cmd_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected wheel command left %0d right %0d turn %0d", $time,
                 left_speed, right_speed, turn_rate);
      end else begin
        want = wheel_cmd_q.pop_front();
        if ({left_speed, right_speed, turn_rate} !== want) begin
          mismatch_count++;
          $display("%0t: expected left %0d right %0d turn %0d, got left %0d right %0d turn %0d",
                   $time, want.left, want.right, want.turn, left_speed, right_speed, turn_rate);
        end
      end
    end
  end

  initial begin
    logic [31:0] v;
    logic signed [15:0] e;
    int sel;
    stim_row_t row;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        drain();
        reg_write(row.idx, row.data);
      end else begin
        send_sample(row.data[15:0], row.typed, row.cmd);
      end
    end

    // phase 0 restores reset values, 1 and 2 pin every register at an extreme
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      steady = (phase == 3);
      for (int r = 0; r < NUM_REGS; r++) begin
        v = $urandom;
        case (reg_idx_t'(r))
          REG_BASE_SPEED:
            v = (phase == 0) ? BASE_SPEED_RST : (phase == 1) ? 32'h7FFF_FFFF :
                (phase == 2) ? 32'h8000_0000 :
                ($urandom_range(3) == 0) ? v : $urandom_range(2 ** 21) - 2 ** 20;
          REG_TRACK_WIDTH:
            v = (phase == 0) ? {16'h0, TRACK_WIDTH_RST} : (phase == 1) ? 32'hFFFF :
                (phase == 2) ? 32'h0 : v;
          default: begin
            if (phase == 0) begin
              v = (reg_idx_t'(r) == REG_GAIN_P) ? 32'(GAIN_P_RST) :
                  (reg_idx_t'(r) == REG_GAIN_I) ? 32'(GAIN_I_RST) : 32'(GAIN_D_RST);
            end else if (phase == 1) begin
              v = 32'h7FFF;
            end else if (phase == 2) begin
              v = 32'h8000;
            end else if ($urandom_range(3) != 0) begin
              v[15:0] = 16'($urandom_range(2048) - 1024);
            end
          end
        endcase
        reg_write(3'(r), v);
      end
      repeat (PHASE_ITEMS) begin
        sel = $urandom_range(99);
        if (sel < 55) begin
          e = 16'($urandom_range(4000) - 2000);
        end else if (sel < 70) begin
          case ($urandom_range(3))
            0: e = 16'sh7FFF;
            1: e = 16'sh8000;
            2: e = '0;
            default: e = '1;
          endcase
        end else begin
          e = 16'($urandom);
        end
        send_sample(e, 1'b0, '0);
      end
    end

    drain();
    steady = 1'b0;
    repeat (40) @(posedge clk);

    $display("run: %0d error samples over %0d gain settings, %0d register writes",
             samples_sent, PHASES + 1, reg_writes);
    $display("run: %0d samples drove the turn rate into saturation, %0d mismatches",
             turn_clipped, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/wpdd_pkg.sv
hdl/wpdd_ram.sv
hdl/windowed_pid_differential_drive_top.sv
hdl/wpdd_checker.sv
tb/sv/testbench.sv
